@@ sv/bam_pkg.sv @@
// Shared constants, codes and types for the byte-addressed data memory.
`timescale 1ns / 1ps
`default_nettype none

package bam_pkg;

    // Memory size in bytes and its split into four byte lanes
    localparam int MEMORY_BYTES = 65536;
    localparam int LANES        = 4;
    localparam int ROWS         = (MEMORY_BYTES + LANES - 1) / LANES;
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SPAN_W       = 33;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Request to one byte lane
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [7:0]       wbyte;
    } t_lane_req;

    // Read bookkeeping carried alongside the lane read
    typedef struct packed {
        logic       ok;
        logic [1:0] offset;
        logic [1:0] size;
        logic       sext;
    } t_rd_info;

endpackage

`default_nettype wire

@@ sv/bam_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_en,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    output      logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // On enable, write when i_we is set, otherwise register the read word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/bam_decode.sv @@
// Access decode: range check, per-lane rows, write enables and write bytes.
`timescale 1ns / 1ps
`default_nettype none

module bam_decode
    import bam_pkg::*;
(
    input  wire logic                    i_cmd,
    input  wire logic [1:0]              i_access_size,
    input  wire logic                    i_sign_extend,
    input  wire logic [31:0]             i_byte_address,
    input  wire logic [31:0]             i_write_data,
    output      t_lane_req [LANES-1:0]   o_lane,
    output      t_rd_info                o_info
);

    logic [2:0]        len;
    logic              ok;
    logic [ROW_W-1:0]  base_row;
    logic [1:0]        low;

    // Turn the size code into a byte count; unused code gives zero
    always_comb begin
        case (i_access_size)
            SIZE_BYTE: len = 3'd1;
            SIZE_HALF: len = 3'd2;
            SIZE_WORD: len = 3'd4;
            default:   len = 3'd0;
        endcase
    end

    // Accept only spans that lie wholly inside the memory
    assign ok = (len != 3'd0) &&
                (({1'b0, i_byte_address} + SPAN_W'(len)) <= SPAN_W'(MEMORY_BYTES));

    assign base_row = ROW_W'(i_byte_address >> 2);
    assign low      = i_byte_address[1:0];

    // Lanes below the start offset take the byte from the next row
    always_comb begin
        logic [1:0] off;
        for (int l = 0; l < LANES; l++) begin
            off             = 2'(l) - low;
            o_lane[l].row   = base_row + ROW_W'(2'(l) < low);
            o_lane[l].we    = (i_cmd == CMD_WRITE) && ok && ({1'b0, off} < len);
            o_lane[l].wbyte = 8'(i_write_data >> {off, 3'b000});
        end
    end

    assign o_info.ok     = ok;
    assign o_info.offset = low;
    assign o_info.size   = i_access_size;
    assign o_info.sext   = i_sign_extend;

endmodule

`default_nettype wire

@@ sv/bam_extract.sv @@
// Read assembly: rotate lane bytes into order, then zero- or sign-extend.
`timescale 1ns / 1ps
`default_nettype none

module bam_extract
    import bam_pkg::*;
(
    input  wire logic [LANES-1:0][7:0] i_lane_data,
    input  wire t_rd_info              i_info,
    output      logic [31:0]           o_value
);

    logic [LANES-1:0][7:0] ordered;

    // Pick byte k from the lane that held address base + k
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            ordered[k] = i_lane_data[2'(i_info.offset + 2'(k))];
        end
    end

    // Extend to 32 bits; out-of-range or unused size reads as zero
    always_comb begin
        o_value = 32'd0;
        if (i_info.ok) begin
            case (i_info.size)
                SIZE_BYTE: o_value = {{24{i_info.sext & ordered[0][7]}}, ordered[0]};
                SIZE_HALF: o_value = {{16{i_info.sext & ordered[1][7]}},
                                      ordered[1], ordered[0]};
                SIZE_WORD: o_value = ordered;
                default:   o_value = 32'd0;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/byte_addressed_data_memory.sv @@
// Top level of the byte-addressed little-endian data memory.
// Path: a read passes the input stage, lane read stage and result stage registers in that order.
// Throughput: one access per cycle while o_stall is low; reads give one result beat, writes give none.
// The four byte-lane RAMs have one port each, so an access reads or writes all lanes once.
// Reset: a clearing pass zeroes the memory one row of four bytes a cycle,
// all ROWS (16384) rows, while o_stall holds high.
`timescale 1ns / 1ps
`default_nettype none

module byte_addressed_data_memory
    import bam_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic        i_cmd,
    input  wire logic [1:0]  i_access_size,
    input  wire logic        i_sign_extend,
    input  wire logic [31:0] i_byte_address,
    input  wire logic [31:0] i_write_data,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [31:0] o_read_data
);

    // Clearing sequencer
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    // Input stage
    logic        r_s1_valid;
    logic        r_s1_cmd;
    logic [1:0]  r_s1_size;
    logic        r_s1_sext;
    logic [31:0] r_s1_addr;
    logic [31:0] r_s1_wdata;

    // Lane read stage
    logic        r_s2_valid;
    t_rd_info    r_s2_info;

    // Result stage
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic                  adv;
    logic                  accept;
    t_lane_req [LANES-1:0] lane_req;
    t_rd_info              s1_info;
    logic [LANES-1:0][7:0] lane_rdata;
    logic [31:0]           value;

    // Advance the pipeline whenever the result register can move on
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_clr_busy || !adv;
    assign accept  = i_valid && !o_stall;

    // Step through every row once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid && (r_s1_cmd == CMD_READ);
            r_out_valid <= r_s2_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_cmd;
            r_s1_size  <= i_access_size;
            r_s1_sext  <= i_sign_extend;
            r_s1_addr  <= i_byte_address;
            r_s1_wdata <= i_write_data;
        end
        if (adv) begin
            r_s2_info  <= s1_info;
            r_out_data <= value;
        end
    end

    bam_decode u_decode (
        .i_cmd          (r_s1_cmd),
        .i_access_size  (r_s1_size),
        .i_sign_extend  (r_s1_sext),
        .i_byte_address (r_s1_addr),
        .i_write_data   (r_s1_wdata),
        .o_lane         (lane_req),
        .o_info         (s1_info)
    );

    // One RAM per byte lane; the clearing pass takes the port while busy
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        bam_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (r_clr_busy || (adv && r_s1_valid)),
            .i_we    (r_clr_busy || lane_req[l].we),
            .i_addr  (r_clr_busy ? r_clr_row : lane_req[l].row),
            .i_wdata (r_clr_busy ? 8'd0 : lane_req[l].wbyte),
            .o_rdata (lane_rdata[l])
        );
    end

    bam_extract u_extract (
        .i_lane_data (lane_rdata),
        .i_info      (r_s2_info),
        .o_value     (value)
    );

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

`default_nettype wire

@@ sv/bam_checker.sv @@
// Port-level checks for the byte-addressed data memory, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bam_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_read_data
);

    // A stalled result beat stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_read_data))
        else $error("result data changed while stalled");

    // Reset starts the clearing pass with an empty pipeline
    assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("no clearing stall or stray result after reset");

    // Nothing drains out for the first cycles after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> ##1 !o_valid ##1 !o_valid)
        else $error("result beat appeared during clearing pass");

endmodule

bind byte_addressed_data_memory bam_checker u_bam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data)
);

`default_nettype wire
